[hw/rtl/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the seven-segment scanner
// Holds the character decode table, the decode result type and the reset
// value of the lit tick limit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

	localparam int CHAR_W = 8;
	localparam int SEG_W = 8;
	localparam int POS_W = 2;
	localparam int NUM_POS = 3;
	localparam int LIMIT_W = 8;
	localparam int COUNT_W = 8;

	localparam logic [LIMIT_W-1:0] LIT_TICK_LIMIT_RESET = 8'd5;
	localparam logic [POS_W-1:0] DOT_POSITION = 2'd2;
	localparam logic [POS_W-1:0] LAST_POSITION = 2'd2;
	localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [SEG_W-1:0] seg_t;
	typedef logic [POS_W-1:0] pos_t;

	// Result of decoding one character: segment pattern and whether the
	// character is one the display knows.
	typedef struct packed {
		logic known;
		seg_t seg;
	} decode_t;

	function automatic decode_t decode_char(input char_t c);
		decode_t d;
		d.known = 1'b1;
		case (c)
			8'h30, 8'h4F: d.seg = 8'h3F;                 // 0 O
			8'h31: d.seg = 8'h06;                        // 1
			8'h32: d.seg = 8'h5B;                        // 2
			8'h33: d.seg = 8'h4F;                        // 3
			8'h34: d.seg = 8'h66;                        // 4
			8'h35, 8'h53, 8'h73: d.seg = 8'h6D;          // 5 S s
			8'h36: d.seg = 8'h7D;                        // 6
			8'h37: d.seg = 8'h07;                        // 7
			8'h38: d.seg = 8'h7F;                        // 8
			8'h39, 8'h47, 8'h67: d.seg = 8'h6F;          // 9 G g
			8'h41, 8'h61: d.seg = 8'h77;                 // A a
			8'h42, 8'h62: d.seg = 8'h7C;                 // B b
			8'h43: d.seg = 8'h39;                        // C
			8'h63: d.seg = 8'h58;                        // c
			8'h44, 8'h64: d.seg = 8'h5E;                 // D d
			8'h45, 8'h65: d.seg = 8'h79;                 // E e
			8'h46, 8'h66: d.seg = 8'h71;                 // F f
			8'h48: d.seg = 8'h76;                        // H
			8'h68: d.seg = 8'h74;                        // h
			8'h49: d.seg = 8'h30;                        // I
			8'h69: d.seg = 8'h04;                        // i
			8'h4A, 8'h6A: d.seg = 8'h1E;                 // J j
			8'h4C, 8'h6C: d.seg = 8'h38;                 // L l
			8'h4E, 8'h6E: d.seg = 8'h54;                 // N n
			8'h6F: d.seg = 8'h5C;                        // o
			8'h50, 8'h70: d.seg = 8'h73;                 // P p
			8'h51, 8'h71: d.seg = 8'h67;                 // Q q
			8'h52, 8'h72: d.seg = 8'h50;                 // R r
			8'h54, 8'h74: d.seg = 8'h78;                 // T t
			8'h55, 8'h75: d.seg = 8'h3E;                 // U u
			8'h56, 8'h76: d.seg = 8'h1C;                 // V v
			8'h59, 8'h79: d.seg = 8'h6E;                 // Y y
			8'h2D: d.seg = 8'h40;                        // minus
			8'h2B: d.seg = 8'hFF;                        // plus
			default: begin
				d.known = 1'b0;
				d.seg = '0;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ssm_char_decode.sv]
// ----------------------------------------------------------------------------
// ssm_char_decode: character select and segment decode
// Picks the character of the scanned position, decodes it and adds the
// decimal point on the dot position when the direction flag is set.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_char_decode (
	input  wire ssm_pkg::char_t   char_pos0,
	input  wire ssm_pkg::char_t   char_pos1,
	input  wire ssm_pkg::char_t   char_pos2,
	input  wire logic             dir_flag,
	input  wire ssm_pkg::pos_t    position,
	output ssm_pkg::decode_t      dec
);

	ssm_pkg::char_t   ch;
	ssm_pkg::decode_t raw;

	always_comb begin
		case (position)
			2'd0: ch = char_pos0;
			2'd1: ch = char_pos1;
			2'd2: ch = char_pos2;
			default: ch = '0;
		endcase
	end

	assign raw = ssm_pkg::decode_char(ch);

	always_comb begin
		dec = raw;
		if (dir_flag && position == ssm_pkg::DOT_POSITION) begin
			dec.seg = raw.seg | ssm_pkg::DOT_BIT;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ssm_scan_state.sv]
// ----------------------------------------------------------------------------
// ssm_scan_state: scan sequencer and display registers
// Holds the blank/lit phase, tick count, scan position and the segment and
// enable registers, which are also the result seen at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_scan_state (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire logic [ssm_pkg::LIMIT_W-1:0]       lit_tick_limit,
	input  wire ssm_pkg::decode_t                  dec,
	output ssm_pkg::pos_t                          scan_position_q,
	output ssm_pkg::seg_t                          segment_q,
	output logic [ssm_pkg::NUM_POS-1:0]            enable_q
);

	logic                              lit_phase_q;
	logic [ssm_pkg::COUNT_W-1:0]       tick_count_q;
	logic [ssm_pkg::COUNT_W:0]         tick_next;
	logic                              lit_done;
	logic [ssm_pkg::NUM_POS-1:0]       pos_bit;

	// The count is compared one bit wider, so a limit of 255 gives 256 ticks.
	assign tick_next = {1'b0, tick_count_q} + 9'd1;
	assign lit_done = tick_next > {1'b0, lit_tick_limit};

	always_comb begin
		case (scan_position_q)
			2'd0: pos_bit = 3'b001;
			2'd1: pos_bit = 3'b010;
			2'd2: pos_bit = 3'b100;
			default: pos_bit = 3'b000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_phase_q <= 1'b0;
			tick_count_q <= '0;
			scan_position_q <= '0;
			segment_q <= '0;
			enable_q <= '0;
		end else if (advance) begin
			if (!lit_phase_q) begin
				lit_phase_q <= 1'b1;
			end else begin
				segment_q <= dec.seg;
				if (lit_done) begin
					lit_phase_q <= 1'b0;
					tick_count_q <= '0;
					enable_q <= '0;
					scan_position_q <= (scan_position_q >= ssm_pkg::LAST_POSITION) ?
						'0 : scan_position_q + 2'd1;
				end else begin
					tick_count_q <= tick_next[ssm_pkg::COUNT_W-1:0];
					if (dec.known) begin
						enable_q <= enable_q | pos_bit;
					end
				end
			end
		end
	end

	// Only the digit being scanned may ever be enabled.
	a_enable_matches_position: assert property (@(posedge clk) disable iff (!arst_n)
		(enable_q & ~pos_bit) == '0)
		else $error("digit enable set outside the scanned position");

	// During the blank phase every digit is off and the count is idle.
	a_blank_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		!lit_phase_q |-> (enable_q == '0 && tick_count_q == '0))
		else $error("digit enabled or count running in blank phase");

	// The position never reaches three.
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_position_q != 2'd3)
		else $error("scan position out of range");

	// Leaving the lit phase steps the position on.
	a_position_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && lit_phase_q && lit_done) |=>
		(scan_position_q != $past(scan_position_q)))
		else $error("scan position did not advance at end of lit phase");

endmodule

`default_nettype wire

[hw/rtl/seven_segment_mux_scanner.sv]
// Timing: an accepted item waits in the input register until the result slot
// is free or being emptied, and is then written into the display registers.
// Throughput: one item per cycle when not stalled, set by the single decode
// and count update between the input register and the display registers.
// Reset: arst_n clears phase, count, position, segments and enables and sets
// the lit tick limit to 5; no clearing pass follows.
// ----------------------------------------------------------------------------
// seven_segment_mux_scanner: three-digit multiplexed seven-segment scanner
// Takes one tick item per cycle unless stalled and returns the segment drive,
// digit enables and scan position after that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_mux_scanner (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          lit_tick_limit_we,
	input  wire logic [ssm_pkg::LIMIT_W-1:0]   lit_tick_limit_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire ssm_pkg::char_t                char_pos0,
	input  wire ssm_pkg::char_t                char_pos1,
	input  wire ssm_pkg::char_t                char_pos2,
	input  wire logic                          dir_flag,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output ssm_pkg::seg_t                      segments,
	output logic [ssm_pkg::NUM_POS-1:0]        digit_enables,
	output ssm_pkg::pos_t                      lit_position
);

	logic [ssm_pkg::LIMIT_W-1:0] lit_tick_limit_q;
	logic                        valid_s1;
	ssm_pkg::char_t              char0_s1;
	ssm_pkg::char_t              char1_s1;
	ssm_pkg::char_t              char2_s1;
	logic                        dir_s1;
	logic                        out_valid_q;
	logic                        accept;
	logic                        advance;
	ssm_pkg::decode_t            dec;

	// An item moves on into the display registers whenever the result slot
	// is free or being emptied in the same cycle.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_tick_limit_q <= ssm_pkg::LIT_TICK_LIMIT_RESET;
		end else if (lit_tick_limit_we) begin
			lit_tick_limit_q <= lit_tick_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char0_s1 <= char_pos0;
			char1_s1 <= char_pos1;
			char2_s1 <= char_pos2;
			dir_s1 <= dir_flag;
		end
	end

	ssm_char_decode u_decode (
		.char_pos0 (char0_s1),
		.char_pos1 (char1_s1),
		.char_pos2 (char2_s1),
		.dir_flag  (dir_s1),
		.position  (lit_position),
		.dec       (dec)
	);

	ssm_scan_state u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.lit_tick_limit  (lit_tick_limit_q),
		.dec             (dec),
		.scan_position_q (lit_position),
		.segment_q       (segments),
		.enable_q        (digit_enables)
	);

endmodule

`default_nettype wire
